// ----- design/sad_pkg.sv -----
// ----------------------------------------------------------------------------
// sad_pkg
// Shared constants and types for the 16x16 SAD block with early exit.
// ----------------------------------------------------------------------------
package sad_pkg;

  // Block geometry
  localparam int unsigned BLOCK_ROWS = 16;
  localparam int unsigned RowW       = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(BLOCK_ROWS - 1);

  // Lane geometry: eight bytes per lane, two lanes per row
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LaneBytes = 8;
  localparam int unsigned LaneW     = ByteW * LaneBytes;
  localparam int unsigned LaneSumW  = ByteW + $clog2(LaneBytes);

  // Running total
  localparam int unsigned SumW = 16;
  localparam int unsigned AccW = SumW + 1;

  // Per-row control carried from the input stage to the accumulator
  typedef struct packed {
    logic            first;
    logic            last;
    logic [SumW-1:0] limit;
  } sad_ctl_t;

endpackage

// ----- design/sad_16x16_early_exit.sv -----
// ----------------------------------------------------------------------------
// sad_16x16_early_exit
// Takes one 16-byte source row and one 16-byte reference row per word and
// accepts a new row every cycle when the output is not stalled. Each row
// goes through two 8-byte lanes (one register stage), then the
// accumulator adds both lane sums to the block total; the result word
// is registered after its last row has left the lane register. The input
// stalls only while the lane stage holds a row and the result word ahead of
// it is stalled. The limit is taken
// from the first row of each block. When the total first exceeds it, one
// word with over_limit set carries the partial total and the remaining rows
// of that block are absorbed without output; otherwise one word with the
// full total follows the block's last row.
// ----------------------------------------------------------------------------
module sad_16x16_early_exit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sad_pkg::LaneW-1:0]   src_bytes_lo_i,
  input  logic [sad_pkg::LaneW-1:0]   src_bytes_hi_i,
  input  logic [sad_pkg::LaneW-1:0]   ref_bytes_lo_i,
  input  logic [sad_pkg::LaneW-1:0]   ref_bytes_hi_i,
  input  logic [sad_pkg::SumW-1:0]    sad_limit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sad_pkg::SumW-1:0]    sad_total_o,
  output logic                        over_limit_o
);
  import sad_pkg::*;

  logic              in_acc;
  logic              adv;
  logic              out_ready;
  logic [RowW-1:0]   row_d, row_q;
  logic              s1_valid_d, s1_valid_q;
  sad_ctl_t          ctl_d, ctl_q;
  logic [LaneSumW-1:0] lo_sad;
  logic [LaneSumW-1:0] hi_sad;

  // Input handshake: lane stage moves on when the output can take it
  assign adv        = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !out_ready);

  // Row position inside the block
  assign row_d = (row_q == LastRow) ? '0 : row_q + RowW'(1);

  // Row control for the accumulator
  always_comb begin
    ctl_d.first = (row_q == '0);
    ctl_d.last  = (row_q == LastRow);
    ctl_d.limit = sad_limit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctl_q <= ctl_d;
    end
  end

  // Two lanes side by side
  sad_lane u_lane_lo (
    .clk_i (clk_i),
    .en_i  (in_acc),
    .a_i   (src_bytes_lo_i),
    .b_i   (ref_bytes_lo_i),
    .sad_o (lo_sad)
  );

  sad_lane u_lane_hi (
    .clk_i (clk_i),
    .en_i  (in_acc),
    .a_i   (src_bytes_hi_i),
    .b_i   (ref_bytes_hi_i),
    .sad_o (hi_sad)
  );

  // Merge lanes into the block total
  sad_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .ctl_i        (ctl_q),
    .lo_sad_i     (lo_sad),
    .hi_sad_i     (hi_sad),
    .out_stall_i  (out_stall_i),
    .out_ready_o  (out_ready),
    .out_valid_o  (out_valid_o),
    .sad_total_o  (sad_total_o),
    .over_limit_o (over_limit_o)
  );

`ifndef ASSERT_OFF
  // The block's last row wraps the row count
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (row_q == LastRow)) |=> (row_q == '0))
    else $error("row count did not wrap after the last row");

  // A held lane word keeps its row control
  a_hold_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_ready) |=> (s1_valid_q && $stable(ctl_q)))
    else $error("lane stage lost a stalled row");
`endif

endmodule

// ----- design/sad_lane.sv -----
// ----------------------------------------------------------------------------
// sad_lane
// Sum of absolute byte differences over one 8-byte lane, registered.
// ----------------------------------------------------------------------------
module sad_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sad_pkg::LaneW-1:0]     a_i,
  input  logic [sad_pkg::LaneW-1:0]     b_i,
  output logic [sad_pkg::LaneSumW-1:0]  sad_o
);
  import sad_pkg::*;

  logic [LaneSumW-1:0] sad_d;
  logic [LaneSumW-1:0] sad_q;

  // Absolute difference per byte, then add them up
  always_comb begin
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] y;
    logic [ByteW-1:0] diff;
    sad_d = '0;
    for (int i = 0; i < LaneBytes; i++) begin
      x    = a_i[i*ByteW +: ByteW];
      y    = b_i[i*ByteW +: ByteW];
      diff = (x > y) ? (x - y) : (y - x);
      sad_d = sad_d + LaneSumW'(diff);
    end
  end

  // Hold the lane result for the accumulator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sad_q <= sad_d;
    end
  end

  assign sad_o = sad_q;

endmodule

// ----- design/sad_accum.sv -----
// ----------------------------------------------------------------------------
// sad_accum
// Merges the lane sums into the block total, checks the limit, and holds
// the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module sad_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  sad_pkg::sad_ctl_t             ctl_i,
  input  logic [sad_pkg::LaneSumW-1:0]  lo_sad_i,
  input  logic [sad_pkg::LaneSumW-1:0]  hi_sad_i,
  input  logic                          out_stall_i,
  output logic                          out_ready_o,
  output logic                          out_valid_o,
  output logic [sad_pkg::SumW-1:0]      sad_total_o,
  output logic                          over_limit_o
);
  import sad_pkg::*;

  logic [SumW-1:0] sum_d, sum_q;
  logic [SumW-1:0] limit_d, limit_q;
  logic            stopped_d, stopped_q;
  logic            out_valid_d, out_valid_q;
  logic [SumW-1:0] total_q;
  logic            over_q;

  logic [SumW-1:0] limit_eff;
  logic [SumW-1:0] base;
  logic            stop_eff;
  logic [AccW-1:0] raw;
  logic [SumW-1:0] sat;
  logic            over;
  logic            emit;

  // Start a fresh block on its first row
  assign limit_eff = ctl_i.first ? ctl_i.limit : limit_q;
  assign stop_eff  = ctl_i.first ? 1'b0 : stopped_q;
  assign base      = ctl_i.first ? '0 : sum_q;

  // Add both lanes, saturate, compare with the limit
  assign raw  = AccW'(base) + AccW'(lo_sad_i) + AccW'(hi_sad_i);
  assign sat  = raw[SumW] ? '1 : raw[SumW-1:0];
  assign over = sat > limit_eff;
  assign emit = adv_i && !stop_eff && (over || ctl_i.last);

  // Next block state
  always_comb begin
    sum_d     = sum_q;
    limit_d   = limit_q;
    stopped_d = stopped_q;
    if (adv_i) begin
      limit_d   = limit_eff;
      stopped_d = stop_eff || over;
      if (!stop_eff) begin
        sum_d = sat;
      end
    end
  end

  // Output word stays until taken
  assign out_ready_o = !out_valid_q || !out_stall_i;
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      limit_q     <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      limit_q     <= limit_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      total_q <= sat;
      over_q  <= over;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sad_total_o  = total_q;
  assign over_limit_o = over_q;

`ifndef ASSERT_OFF
  // A stopped block always holds a total above its limit
  a_stop_above_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (sum_q > limit_q))
    else $error("stopped block with total not above limit");

  // A stopped block emits nothing until the next block starts
  a_no_emit_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && !ctl_i.first && stopped_q) |-> !emit)
    else $error("result emitted after early exit");

  // Never advance into a pending, stalled result word
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !adv_i)
    else $error("row advanced over a stalled result");
`endif

endmodule

// ----- verif/sad_16x16_early_exit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_16x16_early_exit_test
// Streams 16-row blocks into the SAD engine and checks every total word
// against a cycle-free model of the early exit rule. It starts with a few
// hand-built blocks at the rails and at the limit boundaries. Random blocks
// follow, with limits aimed at the running totals. Sender gaps and receiver
// stalls vary over the run.
// ----------------------------------------------------------------------------
module sad_16x16_early_exit_test;
  import sad_pkg::*;

  localparam int unsigned RandomRows = 2000;
  localparam int unsigned RunLimitNs = 5_000_000;
  localparam int unsigned PrintCap   = 40;

  typedef struct packed {
    logic [LaneW-1:0] src_lo;
    logic [LaneW-1:0] src_hi;
    logic [LaneW-1:0] ref_lo;
    logic [LaneW-1:0] ref_hi;
    logic [SumW-1:0]  limit;
  } sad_row_t;

  typedef struct packed {
    logic [SumW-1:0] total;
    logic            over;
  } sad_word_t;

  typedef enum int unsigned {StyleWide, StyleClose, StyleSame, StyleRail} row_style_e;

  // Block total tracker: mirrors the accumulator and queues the words it owes
  class sad_scoreboard;
    int unsigned     errors;
    sad_word_t       owed_words[$];
    logic [SumW-1:0] block_sum;
    logic [SumW-1:0] block_limit;
    int unsigned     row_pos;
    bit              exited;

    function new();
      errors      = 0;
      block_sum   = '0;
      block_limit = '0;
      row_pos     = 0;
      exited      = 1'b0;
    endfunction

    static function int unsigned row_sad(sad_row_t r);
      logic [2*LaneW-1:0] s;
      logic [2*LaneW-1:0] t;
      int unsigned        acc;
      s   = {r.src_hi, r.src_lo};
      t   = {r.ref_hi, r.ref_lo};
      acc = 0;
      for (int i = 0; i < 2 * LaneBytes; i++) begin
        if (s[ByteW*i +: ByteW] > t[ByteW*i +: ByteW]) begin
          acc += s[ByteW*i +: ByteW] - t[ByteW*i +: ByteW];
        end else begin
          acc += t[ByteW*i +: ByteW] - s[ByteW*i +: ByteW];
        end
      end
      return acc;
    endfunction

    // Advance the block state by one accepted row
    function void note_row(sad_row_t r);
      int unsigned acc;
      if (row_pos == 0) begin
        block_sum   = '0;
        exited      = 1'b0;
        block_limit = r.limit;
      end
      if (!exited) begin
        acc = block_sum + row_sad(r);
        if (acc > 32'hFFFF) acc = 32'hFFFF;
        block_sum = SumW'(acc);
        if (block_sum > block_limit) begin
          exited = 1'b1;
          owed_words.push_back('{block_sum, 1'b1});
        end else if (row_pos == BLOCK_ROWS - 1) begin
          owed_words.push_back('{block_sum, 1'b0});
        end
      end
      row_pos = (row_pos == BLOCK_ROWS - 1) ? 0 : row_pos + 1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PrintCap) $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    // Compare one delivered word with the oldest owed one
    task check_total(logic [SumW-1:0] total, logic over);
      sad_word_t want;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected word, total %0d over_limit %b", total, over));
        return;
      end
      want = owed_words.pop_front();
      if (total !== want.total) begin
        report($sformatf("sad_total %0d, want %0d", total, want.total));
      end
      if (over !== want.over) begin
        report($sformatf("over_limit %b, want %b (total %0d)", over, want.over, want.total));
      end
    endtask
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic [LaneW-1:0] src_bytes_lo_i = '0;
  logic [LaneW-1:0] src_bytes_hi_i = '0;
  logic [LaneW-1:0] ref_bytes_lo_i = '0;
  logic [LaneW-1:0] ref_bytes_hi_i = '0;
  logic [SumW-1:0]  sad_limit_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [SumW-1:0]  sad_total_o;
  logic             over_limit_o;

  sad_scoreboard sb = new();
  sad_row_t      block_rows [BLOCK_ROWS];
  int unsigned   burst_left = 0;
  bit            steady     = 1'b0;
  int unsigned   stall_mode = 0;
  int unsigned   mode_left  = 0;
  int unsigned   stall_run  = 0;

  sad_16x16_early_exit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .src_bytes_lo_i (src_bytes_lo_i),
    .src_bytes_hi_i (src_bytes_hi_i),
    .ref_bytes_lo_i (ref_bytes_lo_i),
    .ref_bytes_hi_i (ref_bytes_hi_i),
    .sad_limit_i    (sad_limit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sad_total_o    (sad_total_o),
    .over_limit_o   (over_limit_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver backpressure: switch between quiet, light and heavy phases
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    if (stall_run != 0) begin
      stall_run--;
    end else if (stall_mode == 1 && $urandom_range(0, 3) == 0) begin
      stall_run = $urandom_range(1, 3);
    end else if (stall_mode == 2 && $urandom_range(0, 1) == 0) begin
      stall_run = $urandom_range(1, 8);
    end
    out_stall_i <= (stall_run != 0);
  end

  // Track accepted rows
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o === 1'b0) begin
      sb.note_row('{src_bytes_lo_i, src_bytes_hi_i, ref_bytes_lo_i, ref_bytes_hi_i,
                    sad_limit_i});
    end
  end

  // Check delivered words
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      sb.check_total(sad_total_o, over_limit_o);
    end
  end

  // Drive one row and hold it until accepted; insert a random gap, possibly none, between bursts
  task automatic send_row(input sad_row_t r);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    src_bytes_lo_i <= r.src_lo;
    src_bytes_hi_i <= r.src_hi;
    ref_bytes_lo_i <= r.ref_lo;
    ref_bytes_hi_i <= r.ref_hi;
    sad_limit_i    <= r.limit;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_block();
    for (int r = 0; r < BLOCK_ROWS; r++) send_row(block_rows[r]);
  endtask

  // Hold the sender until every owed word has come out
  task automatic drain_totals();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic sad_row_t rand_row(row_style_e style);
    sad_row_t           r;
    logic [2*LaneW-1:0] s;
    logic [2*LaneW-1:0] t;
    s = {$urandom, $urandom, $urandom, $urandom};
    t = {$urandom, $urandom, $urandom, $urandom};
    case (style)
      StyleClose: begin
        t = s ^ (t & {2*LaneBytes{8'h07}});
      end
      StyleSame: begin
        t = s;
      end
      StyleRail: begin
        for (int i = 0; i < 2 * LaneBytes; i++) begin
          s[ByteW*i +: ByteW] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          t[ByteW*i +: ByteW] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
      end
      default: ;
    endcase
    r.src_lo = s[LaneW-1:0];
    r.src_hi = s[2*LaneW-1:LaneW];
    r.ref_lo = t[LaneW-1:0];
    r.ref_hi = t[2*LaneW-1:LaneW];
    r.limit  = SumW'($urandom_range(0, 16'hFFFF));
    return r;
  endfunction

  initial begin
    int unsigned rows_done;
    int unsigned blk_no;
    int unsigned acc;
    int unsigned lim;
    int unsigned k;
    int unsigned pick;
    int unsigned cum [BLOCK_ROWS];
    row_style_e  style;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Rails in both directions: exit lands on the very last row
    for (int r = 0; r < BLOCK_ROWS; r++) begin
      block_rows[r] = '{{LaneW{1'b1}}, {LaneW{1'b0}}, {LaneW{1'b0}}, {LaneW{1'b1}},
                        16'hFFFF};
    end
    block_rows[0].limit = 16'(65279);
    send_block();

    // Same data, limit equal to the full total: no exit, full total out
    block_rows[0].limit = 16'(65280);
    send_block();

    // Zero difference with a zero limit: total stays at the limit
    for (int r = 0; r < BLOCK_ROWS; r++) begin
      block_rows[r]        = rand_row(StyleSame);
      block_rows[r].limit  = 16'hFFFF;
    end
    block_rows[0].limit = '0;
    send_block();

    // Zero limit with a difference on the first row: exit at once, absorb the rest
    for (int r = 0; r < BLOCK_ROWS; r++) block_rows[r] = rand_row(StyleWide);
    block_rows[0].ref_lo = ~block_rows[0].src_lo;
    block_rows[0].limit  = '0;
    send_block();

    drain_totals();

    // Random blocks with limits aimed at the running totals
    rows_done = 0;
    blk_no    = 0;
    while (rows_done < RandomRows) begin
      steady = (blk_no >= 20 && blk_no < 30);
      if (blk_no == 60) drain_totals();
      style = row_style_e'($urandom_range(0, 3));
      acc   = 0;
      for (int r = 0; r < BLOCK_ROWS; r++) begin
        block_rows[r] = rand_row(($urandom_range(0, 3) == 0) ?
                                 row_style_e'($urandom_range(0, 3)) : style);
        acc += sb.row_sad(block_rows[r]);
        cum[r] = (acc > 32'hFFFF) ? 32'hFFFF : acc;
      end
      k    = $urandom_range(0, BLOCK_ROWS - 1);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        lim = (cum[k] == 0) ? 0 : cum[k] - 1;
      end else if (pick < 6) begin
        lim = cum[BLOCK_ROWS-1];
      end else if (pick < 8) begin
        lim = $urandom_range(0, 16'hFFFF);
      end else if (pick == 8) begin
        lim = 0;
      end else begin
        lim = 16'hFFFF;
      end
      block_rows[0].limit = SumW'(lim);
      send_block();
      rows_done += BLOCK_ROWS;
      blk_no++;
    end

    // Wind down and let the pipeline empty
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.owed_words.size() != 0) begin
      sb.report($sformatf("%0d words never arrived", sb.owed_words.size()));
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RunLimitNs);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
design/sad_pkg.sv
design/sad_lane.sv
design/sad_accum.sv
design/sad_16x16_early_exit.sv
verif/sad_16x16_early_exit_test.sv
